// ===== rtl/csr_edge_stream_builder_assert.svh =====
// Assertion macros used by the checker file of the edge stream builder.
`ifndef CSR_EDGE_STREAM_BUILDER_ASSERT_SVH
`define CSR_EDGE_STREAM_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSEB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cseb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cseb assertion failed");

`endif

// ===== rtl/cseb_pkg.sv =====
package cseb_pkg;

	// Field widths.
	localparam int VERTEX_BITS = 24;
	localparam int EDGE_BITS   = 32;
	localparam int ROW_BITS    = VERTEX_BITS + 1;

	// Item kinds on both channels.
	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Reset value of the vertex count register: 2^VERTEX_BITS.
	localparam logic [ROW_BITS-1:0] NODE_LIMIT_RESET = {1'b1, {VERTEX_BITS{1'b0}}};

	// Saturation value of the kept edge counter.
	localparam logic [EDGE_BITS-1:0] EDGE_COUNT_MAX = {EDGE_BITS{1'b1}};

	// One result item.
	typedef struct packed {
		logic                   out_kind;
		logic [EDGE_BITS-1:0]   edge_position;
		logic [VERTEX_BITS-1:0] source_vertex;
		logic [VERTEX_BITS-1:0] adjacent_vertex;
		logic                   new_row;
		logic [ROW_BITS-1:0]    row_first;
		logic [ROW_BITS-1:0]    row_last;
		logic                   overflow;
	} cseb_result_t;

endpackage

// ===== rtl/cseb_edge_if.sv =====
interface cseb_edge_if import cseb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   kind;
	logic [VERTEX_BITS-1:0] in_source;
	logic [VERTEX_BITS-1:0] in_target;

	modport source (output valid, kind, in_source, in_target, input ready);
	modport sink (input valid, kind, in_source, in_target, output ready);
endinterface

// ===== rtl/cseb_result_if.sv =====
interface cseb_result_if import cseb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   out_kind;
	logic [EDGE_BITS-1:0]   edge_position;
	logic [VERTEX_BITS-1:0] source_vertex;
	logic [VERTEX_BITS-1:0] adjacent_vertex;
	logic                   new_row;
	logic [ROW_BITS-1:0]    row_first;
	logic [ROW_BITS-1:0]    row_last;
	logic                   overflow;

	modport source (output valid, out_kind, edge_position, source_vertex, adjacent_vertex,
		new_row, row_first, row_last, overflow, input ready);
	modport sink (input valid, out_kind, edge_position, source_vertex, adjacent_vertex,
		new_row, row_first, row_last, overflow, output ready);
endinterface

// ===== rtl/cseb_core.sv =====
module cseb_core import cseb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ROW_BITS-1:0]    node_limit,
	input  logic                   item_fire,
	input  logic                   item_kind,
	input  logic [VERTEX_BITS-1:0] item_source,
	input  logic [VERTEX_BITS-1:0] item_target,
	output logic                   res_valid,
	output cseb_result_t           res
);

	logic [VERTEX_BITS-1:0] prev_source_q;
	logic [VERTEX_BITS-1:0] prev_target_q;
	logic                   have_prev_q;
	logic [EDGE_BITS-1:0]   kept_count_q;

	logic [ROW_BITS-1:0] first_row;
	logic                is_finish;
	logic                drop_edge;
	logic                keep_edge;
	logic                saturated;

	// First begin entry that a new row range would cover.
	assign first_row = have_prev_q ? ({1'b0, prev_source_q} + ROW_BITS'(1)) : '0;
	assign is_finish = (item_kind == KIND_FINISH);
	assign saturated = (kept_count_q == EDGE_COUNT_MAX);

	// Self loops, repeats of the last kept edge and reversed edges are dropped.
	assign drop_edge = (item_source == item_target)
		|| (have_prev_q && item_source == prev_source_q && item_target == prev_target_q)
		|| (item_source > item_target);
	assign keep_edge = !is_finish && !drop_edge;

	// Build the result item for the current input item.
	always_comb begin
		res           = '0;
		res_valid     = is_finish || keep_edge;
		res.overflow  = saturated;
		res.edge_position = kept_count_q;
		if (is_finish) begin
			res.out_kind = KIND_FINISH;
			if (first_row <= node_limit) begin
				res.new_row   = 1'b1;
				res.row_first = first_row;
				res.row_last  = node_limit;
			end
		end else begin
			res.out_kind        = KIND_EDGE;
			res.source_vertex   = item_source;
			res.adjacent_vertex = item_target;
			if (!have_prev_q || item_source > prev_source_q) begin
				res.new_row   = 1'b1;
				res.row_first = first_row;
				res.row_last  = {1'b0, item_source};
			end
		end
	end

	// Graph state: last kept edge and the saturating edge counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_source_q <= '0;
			prev_target_q <= '0;
			have_prev_q   <= 1'b0;
			kept_count_q  <= '0;
		end else if (item_fire) begin
			if (is_finish) begin
				prev_source_q <= '0;
				prev_target_q <= '0;
				have_prev_q   <= 1'b0;
				kept_count_q  <= '0;
			end else if (keep_edge) begin
				prev_source_q <= item_source;
				prev_target_q <= item_target;
				have_prev_q   <= 1'b1;
				if (!saturated) begin
					kept_count_q <= kept_count_q + EDGE_BITS'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/cseb_out_buf.sv =====
module cseb_out_buf import cseb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cseb_result_t push_data,
	output logic         push_ready,
	output logic         pop_valid,
	input  logic         pop_ready,
	output cseb_result_t pop_data
);

	cseb_result_t main_q;
	cseb_result_t skid_q;
	logic         main_valid_q;
	logic         skid_valid_q;
	logic         main_load;

	// The skid entry takes an item that arrives while the output is stalled.
	assign push_ready = !skid_valid_q;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;
	assign main_load  = !main_valid_q || pop_ready;

	// Occupancy of the output register and the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_load) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves without reset.
	always_ff @(posedge clk) begin
		if (main_load) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/csr_edge_stream_builder.sv =====
// Channel  Direction  Payload
// in_ch    sink       kind, in_source, in_target
// out_ch   source     out_kind, edge_position, source_vertex, adjacent_vertex,
//                     new_row, row_first, row_last, overflow
// cfg      write      cfg_wdata -> vertex count register
//
// One item is accepted per cycle while in_ch.ready is high; its result goes into
// the output register, or the skid entry while out_ch stalls. The compare against
// the last kept edge and the counter update are done in the accept cycle, so
// back-to-back items see current state. Reset clears the graph state and sets
// the vertex count to 2^24. A two-entry output stage (register plus skid) lets
// in_ch take one more item while out_ch stalls; ready drops only while both entries are full.
module csr_edge_stream_builder import cseb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cseb_edge_if.sink           in_ch,
	cseb_result_if.source       out_ch,
	input  logic                cfg_we,
	input  logic [ROW_BITS-1:0] cfg_wdata
);

	logic [ROW_BITS-1:0] node_limit_q;
	logic                item_fire;
	logic                res_valid;
	logic                buf_ready;
	cseb_result_t        res;
	cseb_result_t        out_data;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_limit_q <= NODE_LIMIT_RESET;
		end else if (cfg_we) begin
			node_limit_q <= cfg_wdata;
		end
	end

	assign in_ch.ready = buf_ready;
	assign item_fire   = in_ch.valid && buf_ready;

	cseb_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_limit   (node_limit_q),
		.item_fire    (item_fire),
		.item_kind    (in_ch.kind),
		.item_source  (in_ch.in_source),
		.item_target  (in_ch.in_target),
		.res_valid    (res_valid),
		.res          (res)
	);

	cseb_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_fire && res_valid),
		.push_data  (res),
		.push_ready (buf_ready),
		.pop_valid  (out_ch.valid),
		.pop_ready  (out_ch.ready),
		.pop_data   (out_data)
	);

	// Unpack the result item onto the output channel.
	assign out_ch.out_kind        = out_data.out_kind;
	assign out_ch.edge_position   = out_data.edge_position;
	assign out_ch.source_vertex   = out_data.source_vertex;
	assign out_ch.adjacent_vertex = out_data.adjacent_vertex;
	assign out_ch.new_row         = out_data.new_row;
	assign out_ch.row_first       = out_data.row_first;
	assign out_ch.row_last        = out_data.row_last;
	assign out_ch.overflow        = out_data.overflow;

endmodule

// ===== rtl/cseb_checker.sv =====
`include "csr_edge_stream_builder_assert.svh"

module cseb_checker import cseb_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   out_kind,
	input logic [EDGE_BITS-1:0]   edge_position,
	input logic [VERTEX_BITS-1:0] source_vertex,
	input logic [VERTEX_BITS-1:0] adjacent_vertex,
	input logic                   new_row,
	input logic [ROW_BITS-1:0]    row_first,
	input logic [ROW_BITS-1:0]    row_last
);

	// A stalled result item holds its position and row range.
	`CSEB_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(edge_position) && $stable(row_first) && $stable(row_last))

	// Without a row range both row fields read zero.
	`CSEB_ASSERT_NOW(a_row_zero, clk, arst_n, out_valid && !new_row, row_first == '0 && row_last == '0)

	// A kept edge always runs from a lower to a higher vertex.
	`CSEB_ASSERT_NOW(a_edge_order, clk, arst_n, out_valid && out_kind == KIND_EDGE, source_vertex < adjacent_vertex)

	// A finish item carries no vertices.
	`CSEB_ASSERT_NOW(a_finish_zero, clk, arst_n, out_valid && out_kind == KIND_FINISH, source_vertex == '0 && adjacent_vertex == '0)

	// An edge that opens a row ends its range at its own source.
	`CSEB_ASSERT_NOW(a_row_end, clk, arst_n, out_valid && out_kind == KIND_EDGE && new_row, row_last == {1'b0, source_vertex})

endmodule

bind csr_edge_stream_builder cseb_checker u_cseb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_kind        (out_ch.out_kind),
	.edge_position   (out_ch.edge_position),
	.source_vertex   (out_ch.source_vertex),
	.adjacent_vertex (out_ch.adjacent_vertex),
	.new_row         (out_ch.new_row),
	.row_first       (out_ch.row_first),
	.row_last        (out_ch.row_last)
);

// ===== dv/csr_stream_checker.sv =====
`timescale 1ns / 100ps

// Watches the edge and result channels, predicts the CSR entry for every
// accepted edge item and compares each accepted result with the oldest one.
module csr_stream_checker import cseb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cseb_edge_if                edge_bus,
	cseb_result_if              result_bus,
	input  logic                cfg_we,
	input  logic [ROW_BITS-1:0] cfg_wdata,
	output int                  fail_count,
	output int                  pending,
	output int                  edge_results,
	output int                  finish_results,
	output int                  dropped_items
);

	localparam int REPORT_LIMIT = 10;

	// Predicted graph state and the vertex count register.
	logic [VERTEX_BITS-1:0] last_source;
	logic [VERTEX_BITS-1:0] last_target;
	logic                   have_last;
	logic [EDGE_BITS-1:0]   kept_edges;
	logic [ROW_BITS-1:0]    node_limit;

	// Predicted CSR entries that have not come out yet, oldest first.
	cseb_result_t csr_entries[$];
	cseb_result_t predicted;
	cseb_result_t observed;

	// Works out the CSR entry that one item causes and updates the state.
	// Returns 0 when the item is dropped.
	function automatic logic predict_csr_entry(input logic kind,
			input logic [VERTEX_BITS-1:0] src, input logic [VERTEX_BITS-1:0] dst,
			output cseb_result_t entry);
		logic [ROW_BITS-1:0] first_row;
		first_row = have_last ? ROW_BITS'(last_source) + 1'b1 : '0;
		entry = '0;
		if (kind == KIND_FINISH) begin
			// Closing row range, then the graph starts over.
			entry.out_kind = KIND_FINISH;
			entry.edge_position = kept_edges;
			if (first_row <= node_limit) begin
				entry.new_row = 1'b1;
				entry.row_first = first_row;
				entry.row_last = node_limit;
			end
			entry.overflow = (kept_edges == EDGE_COUNT_MAX);
			last_source = '0;
			last_target = '0;
			have_last = 1'b0;
			kept_edges = '0;
			return 1'b1;
		end
		// Self loops, repeats of the last kept edge and reversed edges are dropped.
		if (src == dst)
			return 1'b0;
		if (have_last && src == last_source && dst == last_target)
			return 1'b0;
		if (src > dst)
			return 1'b0;
		entry.out_kind = KIND_EDGE;
		entry.edge_position = kept_edges;
		entry.source_vertex = src;
		entry.adjacent_vertex = dst;
		// Only the first kept edge or a source above the last kept one opens rows.
		if (!have_last || src > last_source) begin
			entry.new_row = 1'b1;
			entry.row_first = first_row;
			entry.row_last = ROW_BITS'(src);
		end
		if (kept_edges == EDGE_COUNT_MAX)
			entry.overflow = 1'b1;
		else
			kept_edges = kept_edges + 1'b1;
		last_source = src;
		last_target = dst;
		have_last = 1'b1;
		return 1'b1;
	endfunction

	// Counts a failure and reports the first few in full.
	function automatic void note_failure(input string what, input cseb_result_t want,
			input cseb_result_t got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] %s", $realtime, what);
			$display("  expected kind=%0d pos=%0h src=%0h adj=%0h row=%0d first=%0h last=%0h ovf=%0d",
				want.out_kind, want.edge_position, want.source_vertex, want.adjacent_vertex,
				want.new_row, want.row_first, want.row_last, want.overflow);
			$display("  actual   kind=%0d pos=%0h src=%0h adj=%0h row=%0d first=%0h last=%0h ovf=%0d",
				got.out_kind, got.edge_position, got.source_vertex, got.adjacent_vertex,
				got.new_row, got.row_first, got.row_last, got.overflow);
		end
	endfunction

	// Sample both channels and the register port at every rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_source = '0;
			last_target = '0;
			have_last = 1'b0;
			kept_edges = '0;
			node_limit = NODE_LIMIT_RESET;
			csr_entries.delete();
			fail_count = 0;
			edge_results = 0;
			finish_results = 0;
			dropped_items = 0;
			pending <= 0;
		end else begin
			if (edge_bus.valid && edge_bus.ready) begin
				if (predict_csr_entry(edge_bus.kind, edge_bus.in_source, edge_bus.in_target,
						predicted))
					csr_entries.insert(csr_entries.size(), predicted);
				else
					dropped_items++;
			end
			if (result_bus.valid && result_bus.ready) begin
				observed.out_kind = result_bus.out_kind;
				observed.edge_position = result_bus.edge_position;
				observed.source_vertex = result_bus.source_vertex;
				observed.adjacent_vertex = result_bus.adjacent_vertex;
				observed.new_row = result_bus.new_row;
				observed.row_first = result_bus.row_first;
				observed.row_last = result_bus.row_last;
				observed.overflow = result_bus.overflow;
				if (csr_entries.size() == 0) begin
					note_failure("result item with nothing expected", '0, observed);
				end else begin
					predicted = csr_entries.pop_front();
					if (observed.out_kind !== predicted.out_kind ||
							observed.edge_position !== predicted.edge_position ||
							observed.source_vertex !== predicted.source_vertex ||
							observed.adjacent_vertex !== predicted.adjacent_vertex ||
							observed.new_row !== predicted.new_row ||
							observed.row_first !== predicted.row_first ||
							observed.row_last !== predicted.row_last ||
							observed.overflow !== predicted.overflow)
						note_failure("result item mismatch", predicted, observed);
					if (predicted.out_kind == KIND_FINISH)
						finish_results++;
					else
						edge_results++;
				end
			end
			if (cfg_we)
				node_limit = cfg_wdata;
			pending <= csr_entries.size();
		end
	end

endmodule

// ===== dv/tb_csr_edge_stream_builder.sv =====
`timescale 1ns / 100ps

module tb_csr_edge_stream_builder;
	import cseb_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 8;
	localparam logic [VERTEX_BITS-1:0] VERTEX_MAX = '1;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ROW_BITS-1:0] cfg_wdata;

	cseb_edge_if   in_bus();
	cseb_result_if out_bus();

	int fail_count;
	int pending;
	int edge_results;
	int finish_results;
	int dropped_items;

	int              items_sent;
	int              cfg_writes;
	int              burst_left;
	int              graph_count;
	int              item_limit;
	int              n_edges;
	longint unsigned vertex_setting;
	longint unsigned span;
	bit              offering;
	bit              no_gaps;
	bit              hold_req;

	csr_edge_stream_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	csr_stream_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.edge_bus       (in_bus),
		.result_bus     (out_bus),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.fail_count     (fail_count),
		.pending        (pending),
		.edge_results   (edge_results),
		.finish_results (finish_results),
		.dropped_items  (dropped_items)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("FAIL csr_edge_stream_builder");
		$finish;
	end

	// Offers one item, opening a new burst after a random gap when the last one ran out.
	task automatic send_item(input logic kind, input logic [VERTEX_BITS-1:0] src,
			input logic [VERTEX_BITS-1:0] dst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
			if (no_gaps)
				gap = 0;
			if (gap > 0 && offering) begin
				in_bus.valid <= 1'b0;
				offering = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_bus.valid <= 1'b1;
		in_bus.kind <= kind;
		in_bus.in_source <= src;
		in_bus.in_target <= dst;
		offering = 1'b1;
		items_sent++;
		do @(posedge clk); while (!in_bus.ready);
	endtask

	// Stops offering and waits until every predicted result has come out.
	task automatic drain_results();
		if (offering) begin
			in_bus.valid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the vertex count while the block is idle.
	task automatic write_node_limit(input longint unsigned value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= ROW_BITS'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		vertex_setting = value;
		cfg_writes++;
	endtask

	// Sends a mostly sorted edge list over sources up to span, mixed with
	// self loops, repeats, reversed edges, out-of-order sources and noise.
	task automatic run_graph(input int edge_total, input longint unsigned source_span);
		longint unsigned src;
		longint unsigned tgt;
		longint unsigned step;
		longint unsigned s_prev;
		longint unsigned t_prev;
		int pick;
		step = source_span / longint'(edge_total + 1);
		if (step == 0)
			step = 1;
		s_prev = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 32'(step));
		t_prev = s_prev;
		for (int i = 0; i < edge_total; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(KIND_EDGE, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
			end else if (pick < 12) begin
				send_item(KIND_EDGE, VERTEX_BITS'(s_prev), VERTEX_BITS'(s_prev));
			end else if (pick < 18) begin
				send_item(KIND_EDGE, VERTEX_BITS'(s_prev), VERTEX_BITS'(t_prev));
			end else if (pick < 22) begin
				send_item(KIND_EDGE, VERTEX_BITS'(t_prev), VERTEX_BITS'(s_prev));
			end else begin
				if (pick < 25 && s_prev > 0)
					src = $urandom_range(0, 32'(s_prev - 1));
				else if (pick < 60 || t_prev >= VERTEX_MAX)
					src = s_prev + 1 + $urandom_range(0, 32'(step - 1));
				else
					src = s_prev;
				if (src == s_prev)
					tgt = t_prev + 1 + $urandom_range(0, 7);
				else
					tgt = src + 1 + $urandom_range(0, 32'(step));
				if (src > VERTEX_MAX)
					src = VERTEX_MAX;
				if (tgt > VERTEX_MAX)
					tgt = VERTEX_MAX;
				send_item(KIND_EDGE, VERTEX_BITS'(src), VERTEX_BITS'(tgt));
				s_prev = src;
				t_prev = tgt;
			end
		end
	endtask

	// Receiver: random ready pattern in segments, with a long hold-off on request.
	initial begin
		int seg;
		int mode;
		out_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				seg = $urandom_range(4, 40);
				mode = $urandom_range(0, 3);
				for (int i = 0; i < seg; i++) begin
					case (mode)
						0: out_bus.ready <= 1'b1;
						1: out_bus.ready <= ($urandom_range(0, 3) != 0);
						2: out_bus.ready <= ($urandom_range(0, 2) == 0);
						default: out_bus.ready <= 1'(($urandom_range(0, 1)));
					endcase
					@(posedge clk);
					if (hold_req)
						break;
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_bus.valid <= 1'b0;
		in_bus.kind <= KIND_EDGE;
		in_bus.in_source <= '0;
		in_bus.in_target <= '0;
		items_sent = 0;
		cfg_writes = 0;
		burst_left = 0;
		graph_count = 0;
		offering = 1'b0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		vertex_setting = NODE_LIMIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges at the reset vertex count, starting with a finish on an empty graph.
		send_item(KIND_FINISH, VERTEX_MAX, VERTEX_MAX);
		send_item(KIND_EDGE, '0, VERTEX_MAX);
		send_item(KIND_EDGE, '0, VERTEX_MAX);
		send_item(KIND_EDGE, 24'd5, 24'd5);
		send_item(KIND_EDGE, VERTEX_MAX, '0);
		send_item(KIND_EDGE, '0, 24'd1);
		send_item(KIND_EDGE, 24'd3, 24'd7);
		send_item(KIND_EDGE, 24'd2, 24'd9);
		send_item(KIND_EDGE, VERTEX_MAX - 1'b1, VERTEX_MAX);
		send_item(KIND_EDGE, VERTEX_MAX, VERTEX_MAX);
		send_item(KIND_FINISH, '0, '0);
		send_item(KIND_EDGE, 24'h555555, 24'hAAAAAA);
		send_item(KIND_FINISH, 24'hAAAAAA, 24'h555555);

		// Smallest vertex count: a source past it and an empty closing range.
		write_node_limit(1);
		send_item(KIND_EDGE, '0, 24'd1);
		send_item(KIND_EDGE, 24'd5, 24'd6);
		send_item(KIND_FINISH, '0, '0);
		send_item(KIND_FINISH, VERTEX_MAX, '0);
		write_node_limit(NODE_LIMIT_RESET);

		// Random graphs under changing vertex counts.
		item_limit = items_sent + ITEM_TARGET;
		while (items_sent < item_limit) begin
			if (graph_count == 6) begin
				// Output held off while edges keep coming, so the input must stall.
				drain_results();
				hold_req = 1'b1;
				no_gaps = 1'b1;
				for (int i = 0; i < 24; i++)
					send_item(KIND_EDGE, VERTEX_BITS'(i * 3), VERTEX_BITS'(i * 3 + 1));
				send_item(KIND_FINISH, '0, '0);
				no_gaps = 1'b0;
				drain_results();
			end
			if (graph_count % 4 == 0) begin
				case ($urandom_range(0, 3))
					0: write_node_limit(1);
					1: write_node_limit(NODE_LIMIT_RESET);
					2: write_node_limit($urandom_range(2, 64));
					default: write_node_limit($urandom_range(1, 32'(NODE_LIMIT_RESET)));
				endcase
			end
			n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
			span = ($urandom_range(0, 4) == 0) ? vertex_setting * 2 + 8 : vertex_setting;
			run_graph(n_edges, span);
			if ($urandom_range(0, 5) != 0)
				send_item(KIND_FINISH, VERTEX_BITS'($urandom), VERTEX_BITS'($urandom));
			graph_count++;
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d items over %0d graphs with %0d vertex count writes.",
			items_sent, graph_count, cfg_writes);
		$display("Checked %0d edge results and %0d finish results; %0d items dropped.",
			edge_results, finish_results, dropped_items);
		if (fail_count == 0 && pending == 0)
			$display("PASS csr_edge_stream_builder");
		else
			$display("FAIL csr_edge_stream_builder");
		$finish;
	end

endmodule
